// File: rtl/core/kfd_pkg.sv
// ----------------------------------------------------------------------------
// kfd_pkg: shared types and constants of the KISS frame deframer
// Holds the request and result payload structs, the KISS special byte
// codes, the record kinds and the frame status codes.
// ----------------------------------------------------------------------------
package kfd_pkg;

	localparam int CAP_W      = 10;   // width of the capacity register
	localparam int COUNT_OUT_W = 10;  // width of the reported byte count

	localparam logic [7:0] BYTE_FEND  = 8'hC0;
	localparam logic [7:0] BYTE_FESC  = 8'hDB;
	localparam logic [7:0] BYTE_TFEND = 8'hDC;
	localparam logic [7:0] BYTE_TFESC = 8'hDD;

	localparam logic REC_DATA = 1'b0;
	localparam logic REC_END  = 1'b1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADRX  = 2'd1;
	localparam logic [1:0] ST_BADCMD = 2'd2;
	localparam logic [1:0] ST_OVFL   = 2'd3;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       rx_error;
	} in_t;

	typedef struct packed {
		logic                   record_kind;
		logic [7:0]             data_byte;
		logic [3:0]             port_number;
		logic [COUNT_OUT_W-1:0] byte_count;
		logic [1:0]             status;
	} out_t;

	typedef struct packed {
		logic emit;
		out_t rec;
	} res_t;

endpackage

// File: rtl/core/kfd_parser.sv
// ----------------------------------------------------------------------------
// kfd_parser: KISS framing state and per-byte decode
// Holds the frame state and the capacity register, decodes one request
// per enabled cycle and reports at most one result record for it.
// ----------------------------------------------------------------------------
module kfd_parser #(
	parameter int COUNT_WIDTH = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  kfd_pkg::in_t                  item,
	input  logic                          cfg_we,
	input  logic [kfd_pkg::CAP_W-1:0]     cfg_wdata,
	output kfd_pkg::res_t                 res
);
	import kfd_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W;

	logic                   in_frame_q, expect_cmd_q, esc_q, frame_valid_q;
	logic [3:0]             port_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [CAP_W-1:0]       capacity_q;

	logic                   in_frame_d, expect_cmd_d, esc_d, frame_valid_d;
	logic [3:0]             port_d;
	logic [COUNT_WIDTH-1:0] count_d;
	logic                   go_idle;
	logic [CMP_W-1:0]       count_ext, cap_ext;
	logic [7:0]             c;

	assign count_ext = CMP_W'(count_q);
	assign cap_ext   = CMP_W'(capacity_q);
	assign c         = item.rx_byte;

	always_comb begin
		in_frame_d    = in_frame_q;
		expect_cmd_d  = expect_cmd_q;
		esc_d         = esc_q;
		frame_valid_d = frame_valid_q;
		port_d        = port_q;
		count_d       = count_q;
		go_idle       = 1'b0;
		res           = '0;

		priority if (item.rx_error) begin
			res.emit            = 1'b1;
			res.rec.record_kind = REC_END;
			res.rec.status      = ST_BADRX;
			go_idle             = 1'b1;
		end else if (!in_frame_q) begin
			if (c == BYTE_FEND) begin
				in_frame_d   = 1'b1;
				expect_cmd_d = 1'b1;
			end
		end else if (expect_cmd_q) begin
			expect_cmd_d = 1'b0;
			port_d       = c[7:4];
			if (c[3:0] == 4'd0) begin
				frame_valid_d = 1'b1;
			end else begin
				res.emit            = 1'b1;
				res.rec.record_kind = REC_END;
				res.rec.status      = ST_BADCMD;
				go_idle             = 1'b1;
			end
		end else if (esc_q) begin
			esc_d = 1'b0;
			if (frame_valid_q && (c == BYTE_TFEND || c == BYTE_TFESC)) begin
				res.emit              = 1'b1;
				res.rec.record_kind   = REC_DATA;
				res.rec.data_byte     = (c == BYTE_TFEND) ? BYTE_FEND : BYTE_FESC;
				count_d               = count_q + 1'b1;
			end
		end else if (c == BYTE_FEND) begin
			res.emit            = 1'b1;
			res.rec.record_kind = REC_END;
			res.rec.port_number = port_q;
			res.rec.byte_count  = count_ext[COUNT_OUT_W-1:0];
			res.rec.status      = ST_OK;
			go_idle             = 1'b1;
		end else if (count_ext == cap_ext) begin
			res.emit            = 1'b1;
			res.rec.record_kind = REC_END;
			res.rec.status      = ST_OVFL;
			go_idle             = 1'b1;
		end else if (c == BYTE_FESC) begin
			esc_d = 1'b1;
		end else if (frame_valid_q) begin
			res.emit            = 1'b1;
			res.rec.record_kind = REC_DATA;
			res.rec.data_byte   = c;
			count_d             = count_q + 1'b1;
		end

		if (go_idle) begin
			in_frame_d    = 1'b0;
			expect_cmd_d  = 1'b0;
			esc_d         = 1'b0;
			frame_valid_d = 1'b0;
			port_d        = '0;
			count_d       = COUNT_WIDTH'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			expect_cmd_q  <= 1'b0;
			esc_q         <= 1'b0;
			frame_valid_q <= 1'b0;
			port_q        <= '0;
			count_q       <= COUNT_WIDTH'(1);
			capacity_q    <= '1;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (step) begin
				in_frame_q    <= in_frame_d;
				expect_cmd_q  <= expect_cmd_d;
				esc_q         <= esc_d;
				frame_valid_q <= frame_valid_d;
				port_q        <= port_d;
				count_q       <= count_d;
			end
		end
	end

	// Once the command byte is taken, a frame that is still open is a data frame.
	a_open_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		(in_frame_q && !expect_cmd_q) |-> frame_valid_q)
		else $error("open frame past its command byte is not marked as data");

	a_flags_need_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(esc_q || expect_cmd_q || frame_valid_q) |-> in_frame_q)
		else $error("frame flag set while idle");

	a_error_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.rx_error) |=> (!in_frame_q && count_q == COUNT_WIDTH'(1)))
		else $error("receive error did not return the parser to idle");

	a_data_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.emit && res.rec.record_kind == REC_DATA)
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("data record did not advance the byte count");

endmodule

// File: rtl/core/kiss_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// kiss_frame_deframer_top: KISS receive deframer
// Takes one received byte or receive-error marker per request and returns
// decoded data bytes and one summary record at the end of each frame.
//
//  Channel  Signals                        Dir  Payload
//  -------  -----------------------------  ---  ------------------------------
//  input    in_valid, in_ready, in_data    in   rx_byte, rx_error
//  output   out_valid, out_ready, out_data out  record_kind .. status
//  config   cfg_we, cfg_wdata              in   capacity (10 bits)
//
// A request is registered on acceptance and decoded once it advances out of
// the input stage, where the result, if any, is written to the output register.
// One request is accepted every cycle while the output register drains.
// The output register holds a waiting result; the input stage stalls only when
// both it and the output register are full. Reset sets capacity to 1023 and
// the parser to idle outside any frame.
// ----------------------------------------------------------------------------
module kiss_frame_deframer_top #(
	parameter int COUNT_WIDTH = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  kfd_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output kfd_pkg::out_t                 out_data,
	input  logic                          cfg_we,
	input  logic [kfd_pkg::CAP_W-1:0]     cfg_wdata
);
	import kfd_pkg::*;

	logic valid_s1;
	in_t  item_s1;
	logic out_valid_q;
	out_t out_q;
	logic advance;
	res_t res;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	kfd_parser #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= res.emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (advance && res.emit) begin
			out_q <= res.rec;
		end
	end

endmodule

// File: tb/kfd_deframe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfd_deframe_checker: result predictor and scoreboard for the KISS deframer
// Watches the request, result and capacity ports, decodes every accepted
// request with its own copy of the parser state, and compares each accepted
// result, field by field, with the oldest expected record.
// ----------------------------------------------------------------------------
module kfd_deframe_checker
	import kfd_pkg::*;
#(
	parameter int CNT_W = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  in_t              in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  out_t             out_data,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	output int               fail_count,
	output int               pending
);

	logic             in_frame;
	logic             want_cmd;
	logic             esc_seen;
	logic             data_frame;
	logic [3:0]       frame_port;
	logic [CNT_W-1:0] byte_cnt;
	logic [CAP_W-1:0] capacity;
	out_t             pending_records[$];

	function automatic void clear_frame();
		in_frame   = 1'b0;
		want_cmd   = 1'b0;
		esc_seen   = 1'b0;
		data_frame = 1'b0;
		frame_port = 4'h0;
		byte_cnt   = CNT_W'(1);
	endfunction

	function automatic out_t end_record(input logic [1:0] st);
		out_t rec;
		rec = '0;
		rec.record_kind = REC_END;
		rec.status      = st;
		// Port and count are reported only for a cleanly closed frame.
		if (st == ST_OK) begin
			rec.port_number = frame_port;
			rec.byte_count  = COUNT_OUT_W'(byte_cnt);
		end
		clear_frame();
		return rec;
	endfunction

	function automatic out_t data_record(input logic [7:0] b);
		out_t rec;
		rec = '0;
		rec.record_kind = REC_DATA;
		rec.data_byte   = b;
		byte_cnt        = byte_cnt + CNT_W'(1);
		return rec;
	endfunction

	// Advances the parser by one request; returns 1 when a record comes out.
	function automatic bit decode_req(input in_t req, output out_t rec);
		logic [7:0] b;
		b   = req.rx_byte;
		rec = '0;
		if (req.rx_error) begin
			rec = end_record(ST_BADRX);
			return 1'b1;
		end
		if (!in_frame) begin
			if (b == BYTE_FEND) begin
				in_frame = 1'b1;
				want_cmd = 1'b1;
			end
			return 1'b0;
		end
		if (want_cmd) begin
			want_cmd   = 1'b0;
			frame_port = b[7:4];
			if (b[3:0] == 4'h0) begin
				data_frame = 1'b1;
				return 1'b0;
			end
			rec = end_record(ST_BADCMD);
			return 1'b1;
		end
		// Anything after an escape other than the two transposed codes is dropped,
		// a frame end included, and the capacity is not checked here.
		if (esc_seen) begin
			esc_seen = 1'b0;
			if (data_frame && b == BYTE_TFEND) begin
				rec = data_record(BYTE_FEND);
				return 1'b1;
			end
			if (data_frame && b == BYTE_TFESC) begin
				rec = data_record(BYTE_FESC);
				return 1'b1;
			end
			return 1'b0;
		end
		if (b == BYTE_FEND) begin
			rec = end_record(ST_OK);
			return 1'b1;
		end
		if (byte_cnt == capacity) begin
			rec = end_record(ST_OVFL);
			return 1'b1;
		end
		if (b == BYTE_FESC) begin
			esc_seen = 1'b1;
			return 1'b0;
		end
		if (data_frame) begin
			rec = data_record(b);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_t want;
		out_t made;
		if (!arst_n) begin
			capacity = CAP_W'(1023);
			clear_frame();
			pending_records.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_records.size() == 0) begin
					fail_count++;
					if (fail_count < 50)
						$display("%0t: unexpected result: expected none, got %h",
						         $time, out_data);
				end else begin
					want = pending_records.pop_front();
					if (out_data.record_kind !== want.record_kind ||
					    out_data.data_byte   !== want.data_byte   ||
					    out_data.port_number !== want.port_number ||
					    out_data.byte_count  !== want.byte_count  ||
					    out_data.status      !== want.status) begin
						fail_count++;
						if (fail_count < 50)
							$display("%0t: result mismatch: expected %h, got %h",
							         $time, want, out_data);
					end
				end
			end
			if (cfg_we)
				capacity = cfg_wdata;
			if (in_valid && in_ready) begin
				if (decode_req(in_data, made))
					pending_records.push_back(made);
			end
			pending = pending_records.size();
		end
	end

endmodule

// File: tb/tb_kiss_frame_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kiss_frame_deframer_top: testbench of the KISS receive deframer
// Drives a directed set of frames covering escapes, bad commands, receive
// errors and overflow, then random frames under several capacities with
// random gaps on both sides, a long output stall and one frame of maximum
// length. Checking is done by the checker module beside the block.
// ----------------------------------------------------------------------------
module tb_kiss_frame_deframer_top;
	import kfd_pkg::*;

	localparam int LONG_HOLD = 80;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	in_t              in_data   = '0;
	logic             out_ready = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;
	logic             in_ready;
	logic             out_valid;
	out_t             out_data;
	int               fail_count;
	int               pending;
	int               sent      = 0;
	bit               gaps_on   = 1'b0;
	bit               hold_req  = 1'b0;

	kiss_frame_deframer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	kfd_deframe_checker deframe_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: random stall bursts, plus one long hold on request.
	always begin
		@(negedge clk);
		if (hold_req) begin
			out_ready <= 1'b0;
			repeat (LONG_HOLD) @(negedge clk);
			hold_req = 1'b0;
		end else if (gaps_on && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		out_ready <= 1'b1;
	end

	// Called and returning at a falling edge; valid stays high between back
	// to back requests.
	task automatic send_req(input logic [7:0] b, input logic err);
		in_t req;
		req.rx_byte  = b;
		req.rx_error = err;
		if (gaps_on && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_frame(input int body_len);
		int         pick;
		logic [7:0] cmd;
		pick = $urandom_range(0, 19);
		cmd  = {4'($urandom_range(0, 15)), 4'h0};
		if (pick == 0)
			cmd = BYTE_FEND;
		else if (pick == 1)
			cmd[3:0] = 4'($urandom_range(1, 15));
		repeat ($urandom_range(0, 2)) send_req(8'($urandom_range(0, 255)), 1'b0);
		send_req(BYTE_FEND, 1'b0);
		send_req(cmd, 1'b0);
		repeat (body_len) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_req(BYTE_FESC, 1'b0);
				send_req($urandom_range(0, 1) ? BYTE_TFEND : BYTE_TFESC, 1'b0);
			end else if (pick < 10) begin
				send_req(BYTE_FESC, 1'b0);
				send_req(8'($urandom_range(0, 255)), 1'b0);
			end else if (pick == 10) begin
				send_req(8'($urandom_range(0, 255)), 1'b1);
			end else begin
				send_req(8'($urandom_range(0, 255)), 1'b0);
			end
		end
		if ($urandom_range(0, 9) != 0)
			send_req(BYTE_FEND, 1'b0);
	endtask

	initial begin
		logic [CAP_W-1:0] cap;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Dropped noise, then a receive error while idle.
		send_req(8'h55, 1'b0);
		send_req(8'hFF, 1'b1);
		// Data frame on port 15 with both transposed escapes and a dropped escape.
		send_req(BYTE_FEND, 1'b0);
		send_req(8'hF0, 1'b0);
		send_req(8'h00, 1'b0);
		send_req(8'hFF, 1'b0);
		send_req(BYTE_FESC, 1'b0);
		send_req(BYTE_TFEND, 1'b0);
		send_req(BYTE_FESC, 1'b0);
		send_req(BYTE_TFESC, 1'b0);
		send_req(BYTE_FESC, 1'b0);
		send_req(8'h41, 1'b0);
		send_req(BYTE_FEND, 1'b0);
		// Nonzero command nibble.
		send_req(BYTE_FEND, 1'b0);
		send_req(8'h05, 1'b0);
		// A frame end as the command byte opens a data frame on port 12.
		send_req(BYTE_FEND, 1'b0);
		send_req(BYTE_FEND, 1'b0);
		send_req(8'h12, 1'b0);
		send_req(8'h00, 1'b1);
		// An escaped frame end is dropped and does not close the frame.
		send_req(BYTE_FEND, 1'b0);
		send_req(8'h00, 1'b0);
		send_req(BYTE_FESC, 1'b0);
		send_req(BYTE_FEND, 1'b0);
		send_req(8'h33, 1'b0);
		send_req(BYTE_FEND, 1'b0);

		// Overflow at the smallest capacities.
		write_capacity(CAP_W'(1));
		send_req(BYTE_FEND, 1'b0);
		send_req(8'h00, 1'b0);
		send_req(8'h11, 1'b0);
		write_capacity(CAP_W'(2));
		send_req(BYTE_FEND, 1'b0);
		send_req(8'h70, 1'b0);
		send_req(8'hAA, 1'b0);
		send_req(8'hBB, 1'b0);

		write_capacity(CAP_W'(1023));
		gaps_on  = 1'b1;
		// The result side holds off while requests keep coming, so the block
		// backs up and stalls its input.
		hold_req = 1'b1;
		send_frame(30);

		// Longest frame the largest capacity allows: byte count 1023. A receive
		// error first returns the parser to idle in case the last frame was left open.
		send_req(8'h00, 1'b1);
		send_req(BYTE_FEND, 1'b0);
		send_req(8'h30, 1'b0);
		repeat (1022) send_req(8'($urandom_range(0, 8'hBF)), 1'b0);
		send_req(BYTE_FEND, 1'b0);

		while (sent < 1600) begin
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 3))
					0:       cap = CAP_W'(1);
					1:       cap = CAP_W'(1023);
					default: cap = CAP_W'($urandom_range(2, 40));
				endcase
				write_capacity(cap);
			end
			send_frame($urandom_range(0, 30));
		end

		gaps_on = 1'b0;
		while (sent < 1750)
			send_frame($urandom_range(0, 30));
		in_valid <= 1'b0;

		repeat (20000) if (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (pending != 0)
			$display("%0t: %0d expected results never arrived", $time, pending);
		if (fail_count == 0 && pending == 0)
			$display("tb_kiss_frame_deframer_top: done, clean");
		else
			$display("tb_kiss_frame_deframer_top: done, errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("%0t: timeout", $time);
		$display("tb_kiss_frame_deframer_top: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/kfd_pkg.sv
rtl/core/kfd_parser.sv
rtl/core/kiss_frame_deframer_top.sv
tb/kfd_deframe_checker.sv
tb/tb_kiss_frame_deframer_top.sv
